// File: rtl/assert_macros.svh
// Assertion macros for the files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// File: rtl/gmm_pkg.sv
// Package: sizes, codes and item types of the int8 matrix multiply block.
package gmm_pkg;

   localparam int DEPTH_MAX   = 64;
   localparam int COLUMNS_MAX = 16;

   localparam int DEPTH_W = (DEPTH_MAX > 1) ? $clog2(DEPTH_MAX) : 1;
   localparam int COL_W   = $clog2(COLUMNS_MAX);

   // Operation codes of an input item
   localparam logic [1:0] OP_WEIGHT = 2'd0;
   localparam logic [1:0] OP_BIAS   = 2'd1;
   localparam logic [1:0] OP_ACT    = 2'd2;

   // Register indexes of the configuration port
   localparam logic [1:0] CSR_COLUMN_COUNT = 2'd0;
   localparam logic [1:0] CSR_ROW_COUNT    = 2'd1;
   localparam logic [1:0] CSR_BIAS_ENABLE  = 2'd2;

   // One item as it travels down the row of cells
   typedef struct packed {
      logic               valid;
      logic [1:0]         operation;
      logic [5:0]         depth_index;
      logic [3:0]         column_index;
      logic signed [7:0]  element_value;
      logic signed [31:0] bias_value;
      logic               last_of_row;
      logic               first_of_row;
   } gmm_item_type;

   // What one cell offers to the output register
   typedef struct packed {
      logic               emit;
      logic               last_of_run;
      logic signed [31:0] value;
   } gmm_result_type;

endpackage

// File: rtl/gmm_if.sv
// Stream interfaces: request items in, result items out.
interface gmm_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         operation;
   logic [5:0]         depth_index;
   logic [3:0]         column_index;
   logic signed [7:0]  element_value;
   logic signed [31:0] bias_value;
   logic               last_of_row;

   modport source (output valid, operation, depth_index, column_index, element_value,
                   bias_value, last_of_row, input ready);
   modport sink   (input valid, operation, depth_index, column_index, element_value,
                   bias_value, last_of_row, output ready);
endinterface

interface gmm_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] result_value;
   logic [3:0]         column_number;
   logic [15:0]        row_number;
   logic               last_of_run;

   modport source (output valid, result_value, column_number, row_number, last_of_run,
                   input ready);
   modport sink   (input valid, result_value, column_number, row_number, last_of_run,
                   output ready);
endinterface

// File: rtl/int8_matrix_multiply_bias_top.sv
// Top level: int8 matrix multiply with per-column bias over a row of MAC cells.
//
//   channel       dir   handshake          carries
//   req_channel   in    valid / ready      weight, bias or activation item
//   rsp_channel   out   valid / ready      one column result of a row
//   csr_*         in    write enable only  column_count, row_count, bias_enable
//
// Weight, bias and activation items are taken one per cycle while the result
// register is not stalled and no row is draining; an item passes each cell's
// item stage in turn. After a last-of-row item the input waits until the row's
// final result is taken. A stalled result register freezes the whole cell row.
// Reset clears control state only; stores hold nothing defined until written.
module int8_matrix_multiply_bias_top (
   input  logic       clock,
   input  logic       reset,
   gmm_req_if.sink    req_channel,
   gmm_rsp_if.source  rsp_channel,
   input  logic       csr_write_enable,
   input  logic [1:0] csr_index,
   input  logic [15:0] csr_write_data
);
   import gmm_pkg::*;

`include "assert_macros.svh"

   logic [4:0]         column_count_ff;
   logic [15:0]        row_count_ff;
   logic               bias_enable_ff;
   logic               row_open_ff;
   logic [15:0]        row_counter_ff;
   logic [15:0]        out_row_ff;
   logic               drain_ff;
   logic               rsp_valid_ff;
   logic signed [31:0] rsp_value_ff;
   logic [3:0]         rsp_column_ff;
   logic               rsp_last_ff;

   logic               advance;
   logic               req_accept;
   logic               accept_last;
   logic [16:0]        next_row;
   logic [COL_W-1:0]   last_col;
   gmm_item_type       head_item;
   gmm_item_type       chain [COLUMNS_MAX+1];
   gmm_result_type     results [COLUMNS_MAX];
   logic [COLUMNS_MAX-1:0] emit_vec;
   logic               any_emit;
   logic signed [31:0] sel_value;
   logic [3:0]         sel_column;
   logic               sel_last;

   // Handshake and stall
   assign advance             = !rsp_valid_ff || rsp_channel.ready;
   assign req_channel.ready   = advance && !drain_ff;
   assign req_accept          = req_channel.valid && req_channel.ready;
   assign accept_last         = req_accept && (req_channel.operation == OP_ACT)
                                && req_channel.last_of_row;
   assign next_row            = {1'b0, row_counter_ff} + 17'd1;

   // Columns in use, clamped, as the index of the final column
   always_comb begin
      if (column_count_ff == 5'd0) begin
         last_col = '0;
      end else if (32'(column_count_ff) > COLUMNS_MAX) begin
         last_col = COL_W'(COLUMNS_MAX - 1);
      end else begin
         last_col = COL_W'(column_count_ff - 5'd1);
      end
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         column_count_ff <= 5'd16;
         row_count_ff    <= 16'd65535;
         bias_enable_ff  <= 1'b0;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_COLUMN_COUNT: column_count_ff <= csr_write_data[4:0];
            CSR_ROW_COUNT:    row_count_ff    <= csr_write_data;
            CSR_BIAS_ENABLE:  bias_enable_ff  <= csr_write_data[0];
            default:          ;
         endcase
      end
   end

   // Row tracking and drain after a row's last element
   always_ff @(posedge clock) begin
      if (reset) begin
         row_open_ff    <= 1'b0;
         row_counter_ff <= '0;
         drain_ff       <= 1'b0;
      end else begin
         if (req_accept && (req_channel.operation == OP_ACT)) begin
            row_open_ff <= !req_channel.last_of_row;
         end
         if (accept_last) begin
            drain_ff       <= 1'b1;
            row_counter_ff <= (next_row >= {1'b0, row_count_ff}) ? 16'd0 : next_row[15:0];
         end else if (rsp_valid_ff && rsp_channel.ready && rsp_last_ff) begin
            drain_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept_last) begin
         out_row_ff <= row_counter_ff;
      end
   end

   // Item entering the first cell
   always_comb begin
      head_item.valid         = req_accept;
      head_item.operation     = req_channel.operation;
      head_item.depth_index   = req_channel.depth_index;
      head_item.column_index  = req_channel.column_index;
      head_item.element_value = req_channel.element_value;
      head_item.bias_value    = req_channel.bias_value;
      head_item.last_of_row   = req_channel.last_of_row;
      head_item.first_of_row  = !row_open_ff;
   end

   assign chain[0] = head_item;

   // Row of column cells
   for (genvar c = 0; c < COLUMNS_MAX; c++) begin : g_cell
      gmm_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .advance     (advance),
         .bias_enable (bias_enable_ff),
         .cell_index  (COL_W'(c)),
         .last_col    (last_col),
         .item_in     (chain[c]),
         .item_out    (chain[c+1]),
         .result      (results[c])
      );
      assign emit_vec[c] = results[c].emit;
   end

   // Pick the one cell that finishes a row this cycle
   always_comb begin
      sel_value  = '0;
      sel_column = '0;
      sel_last   = 1'b0;
      for (int c = 0; c < COLUMNS_MAX; c++) begin
         if (results[c].emit) begin
            sel_value  = sel_value | results[c].value;
            sel_column = sel_column | 4'(c);
            sel_last   = sel_last | results[c].last_of_run;
         end
      end
   end

   assign any_emit = |emit_vec;

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= any_emit;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && any_emit) begin
         rsp_value_ff  <= sel_value;
         rsp_column_ff <= sel_column;
         rsp_last_ff   <= sel_last;
      end
   end

   assign rsp_channel.valid         = rsp_valid_ff;
   assign rsp_channel.result_value  = rsp_value_ff;
   assign rsp_channel.column_number = rsp_column_ff;
   assign rsp_channel.row_number    = out_row_ff;
   assign rsp_channel.last_of_run   = rsp_last_ff;

   // Checks
   `ASSERT_SAME(a_one_emitter, 1'b1, $onehot0(emit_vec))
   `ASSERT_SAME(a_result_in_drain, rsp_valid_ff, drain_ff)
   `ASSERT_NEXT(a_last_starts_drain, accept_last, drain_ff && !row_open_ff)

endmodule

// File: rtl/gmm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module gmm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                                      clock,
   input  logic                                      write_enable,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] write_addr,
   input  logic [WIDTH-1:0]                          write_data,
   input  logic                                      read_enable,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] read_addr,
   output logic [WIDTH-1:0]                          read_data_ff
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem_ff[write_addr] <= write_data;
      end
      if (read_enable) begin
         read_data_ff <= mem_ff[read_addr];
      end
   end

endmodule

// File: rtl/gmm_cell.sv
// One column cell: weight memory, bias, accumulator and the item stage.
module gmm_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    advance,
   input  logic                    bias_enable,
   input  logic [gmm_pkg::COL_W-1:0] cell_index,
   input  logic [gmm_pkg::COL_W-1:0] last_col,
   input  gmm_pkg::gmm_item_type   item_in,
   output gmm_pkg::gmm_item_type   item_out,
   output gmm_pkg::gmm_result_type result
);
   import gmm_pkg::*;

   gmm_item_type       item_ff;
   logic signed [31:0] bias_ff;
   logic signed [31:0] acc_ff;
   logic signed [31:0] acc_in;
   logic [7:0]         weight_rd;
   logic               col_hit;
   logic               weight_wr;
   logic               stage_act;
   logic               stage_in_range;
   logic signed [15:0] product;
   logic signed [31:0] base;

   assign col_hit   = (32'(item_in.column_index) == 32'(cell_index));
   assign weight_wr = advance && item_in.valid && (item_in.operation == OP_WEIGHT) && col_hit
                      && (32'(item_in.depth_index) < DEPTH_MAX);

   // Weights of this column, one entry per depth
   gmm_ram #(
      .WIDTH (8),
      .DEPTH (DEPTH_MAX)
   ) u_weights (
      .clock        (clock),
      .write_enable (weight_wr),
      .write_addr   (DEPTH_W'(item_in.depth_index)),
      .write_data   (item_in.element_value),
      .read_enable  (advance),
      .read_addr    (DEPTH_W'(item_in.depth_index)),
      .read_data_ff (weight_rd)
   );

   // Multiply-accumulate on the item held in the stage
   assign stage_act      = item_ff.valid && (item_ff.operation == OP_ACT);
   assign stage_in_range = (32'(item_ff.depth_index) < DEPTH_MAX);
   assign product        = item_ff.element_value * $signed(weight_rd);

   always_comb begin
      if (item_ff.first_of_row) begin
         base = bias_enable ? bias_ff : 32'sd0;
      end else begin
         base = acc_ff;
      end
      acc_in = stage_in_range ? (base + {{16{product[15]}}, product}) : base;
   end

   // Item stage, bias register and accumulator
   always_ff @(posedge clock) begin
      if (reset) begin
         item_ff.valid <= 1'b0;
      end else if (advance) begin
         item_ff.valid <= item_in.valid;
      end
      if (advance) begin
         item_ff.operation     <= item_in.operation;
         item_ff.depth_index   <= item_in.depth_index;
         item_ff.column_index  <= item_in.column_index;
         item_ff.element_value <= item_in.element_value;
         item_ff.bias_value    <= item_in.bias_value;
         item_ff.last_of_row   <= item_in.last_of_row;
         item_ff.first_of_row  <= item_in.first_of_row;
         if (item_in.valid && (item_in.operation == OP_BIAS) && col_hit) begin
            bias_ff <= item_in.bias_value;
         end
         if (stage_act) begin
            acc_ff <= acc_in;
         end
      end
   end

   assign item_out           = item_ff;
   assign result.emit        = stage_act && item_ff.last_of_row && (cell_index <= last_col);
   assign result.last_of_run = (cell_index == last_col);
   assign result.value       = acc_in;

endmodule
